### hdl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared constants and types for the deadline task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  // Default parameter values
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned TASK_BITS_DEF = 8;

  // Fixed field widths on the ports
  localparam int unsigned TASK_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Upper bounds of the parameter ranges, used for width adaption
  localparam int unsigned TIME_MAX_W = 64;
  localparam int unsigned TASK_MAX_W = 16;
  localparam int unsigned CNT_MAX_W  = 9;

  // Port layout
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;

  // Opcode carried on in_tuser
  typedef enum logic {
    OP_ENQ  = 1'b0,
    OP_POLL = 1'b1
  } dtq_op_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic enq;  // insert new entry (queue known not full)
    logic deq;  // pop head, every cell takes its right neighbor
  } dtq_cmd_t;

endpackage

### hdl/dtq_cell.sv
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted shift-register queue.
// ----------------------------------------------------------------------------
module dtq_cell #(
  parameter int unsigned TIME_BITS = dtq_pkg::TIME_BITS_DEF,
  parameter int unsigned TASK_BITS = dtq_pkg::TASK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtq_pkg::dtq_cmd_t    cmd,
  input  logic [TIME_BITS-1:0] new_due,
  input  logic [TASK_BITS-1:0] new_task,
  // left neighbor (earlier slot)
  input  logic                 left_keep,
  input  logic                 left_valid,
  input  logic [TIME_BITS-1:0] left_due,
  input  logic [TASK_BITS-1:0] left_task,
  // right neighbor (later slot)
  input  logic                 right_valid,
  input  logic [TIME_BITS-1:0] right_due,
  input  logic [TASK_BITS-1:0] right_task,
  // own state
  output logic                 keep,
  output logic                 valid,
  output logic [TIME_BITS-1:0] due,
  output logic [TASK_BITS-1:0] task_id
);

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] due_r, due_nxt;
  logic [TASK_BITS-1:0] task_r, task_nxt;

  // entry stays put on insert when it is due no later than the new one
  assign keep = valid_r && (due_r <= new_due);

  always_comb begin
    valid_nxt = valid_r;
    due_nxt   = due_r;
    task_nxt  = task_r;
    if (cmd.enq && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        due_nxt   = new_due;
        task_nxt  = new_task;
      end else begin
        valid_nxt = left_valid;
        due_nxt   = left_due;
        task_nxt  = left_task;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_valid;
      due_nxt   = right_due;
      task_nxt  = right_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    due_r  <= due_nxt;
    task_r <= task_nxt;
  end

  assign valid   = valid_r;
  assign due     = due_r;
  assign task_id = task_r;

endmodule

### hdl/deadline_task_queue_top.sv
// ----------------------------------------------------------------------------
// deadline_task_queue_top
// Earliest-deadline-first task queue on a stream interface.
// ----------------------------------------------------------------------------
// Each input transaction is either an enqueue (in_tuser = 0) carrying a task
// number and an absolute due time, or a poll (in_tuser = 1) carrying the
// current time. Every input transaction yields exactly one output
// transaction. Tasks are held in a row of QUEUE_DEPTH cells kept sorted by
// due time, head in cell 0; equal due times leave in arrival order. An
// enqueue on a full queue is dropped and flagged as rejected. A poll removes
// and reports the head when its due time is <= the current time. Throughput
// is one transaction per clock: the whole row shifts at once, and
// the result sits in an output register, so a new transaction is taken
// while the previous result waits as long as out_tready is high; with
// out_tready low the block holds one result and stalls the input. out_tvalid
// rises in the cycle after acceptance. No clearing pass after reset.
// ----------------------------------------------------------------------------
module deadline_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
  parameter int unsigned TASK_BITS   = dtq_pkg::TASK_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] task_number, [39:8] due_time, [71:40] current_time
  input  logic [dtq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] opcode
  input  logic                             in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_task_number, [39:8] out_due_time, [44:40] occupancy,
  // [45] is_empty, [47:46] zero
  output logic [dtq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] dispatched, [1] rejected
  output logic [dtq_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  // input fields
  logic [dtq_pkg::TASK_W-1:0] f_task;
  logic [dtq_pkg::TIME_W-1:0] f_due;
  logic [dtq_pkg::TIME_W-1:0] f_now;
  logic                       accept;

  assign f_task = in_tdata[7:0];
  assign f_due  = in_tdata[39:8];
  assign f_now  = in_tdata[71:40];
  assign accept = in_tvalid && in_tready;

  // adapt port field widths to the internal TIME_BITS / TASK_BITS
  logic [dtq_pkg::TIME_MAX_W-1:0] due_wide, now_wide;
  logic [dtq_pkg::TASK_MAX_W-1:0] task_wide;
  logic [TIME_BITS-1:0]           new_due, now_time;
  logic [TASK_BITS-1:0]           new_task;

  always_comb begin
    due_wide  = '0;
    now_wide  = '0;
    task_wide = '0;
    due_wide[dtq_pkg::TIME_W-1:0]  = f_due;
    now_wide[dtq_pkg::TIME_W-1:0]  = f_now;
    task_wide[dtq_pkg::TASK_W-1:0] = f_task;
  end

  assign new_due  = due_wide[TIME_BITS-1:0];
  assign now_time = now_wide[TIME_BITS-1:0];
  assign new_task = task_wide[TASK_BITS-1:0];

  // neighbor chain: cell i sits at chain index i+1, ends are empty slots
  logic [QUEUE_DEPTH:0]   keep_w;
  logic [QUEUE_DEPTH+1:0] valid_w;
  logic [TIME_BITS-1:0]   due_w  [QUEUE_DEPTH+2];
  logic [TASK_BITS-1:0]   task_w [QUEUE_DEPTH+2];

  assign keep_w[0]              = 1'b1;   // head inserts the new entry
  assign valid_w[0]             = 1'b0;
  assign due_w[0]               = '0;
  assign task_w[0]              = '0;
  assign valid_w[QUEUE_DEPTH+1] = 1'b0;   // tail pulls in an empty slot
  assign due_w[QUEUE_DEPTH+1]   = '0;
  assign task_w[QUEUE_DEPTH+1]  = '0;

  // control
  dtq_pkg::dtq_cmd_t cmd;
  logic              is_enq, full, dispatch, reject;

  assign is_enq   = (dtq_pkg::dtq_op_t'(in_tuser) == dtq_pkg::OP_ENQ);
  assign full     = valid_w[QUEUE_DEPTH];
  assign dispatch = !is_enq && valid_w[1] && (due_w[1] <= now_time);
  assign reject   = is_enq && full;
  assign cmd.enq  = accept && is_enq && !full;
  assign cmd.deq  = accept && dispatch;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dtq_cell #(
      .TIME_BITS (TIME_BITS),
      .TASK_BITS (TASK_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_due     (new_due),
      .new_task    (new_task),
      .left_keep   (keep_w[i]),
      .left_valid  (valid_w[i]),
      .left_due    (due_w[i]),
      .left_task   (task_w[i]),
      .right_valid (valid_w[i+2]),
      .right_due   (due_w[i+2]),
      .right_task  (task_w[i+2]),
      .keep        (keep_w[i+1]),
      .valid       (valid_w[i+1]),
      .due         (due_w[i+1]),
      .task_id     (task_w[i+1])
    );
  end

  // pending count
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (cmd.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result fields
  logic [dtq_pkg::TIME_MAX_W-1:0] head_due_wide;
  logic [dtq_pkg::TASK_MAX_W-1:0] head_task_wide;
  logic [dtq_pkg::CNT_MAX_W-1:0]  cnt_wide;

  always_comb begin
    head_due_wide  = '0;
    head_task_wide = '0;
    cnt_wide       = '0;
    if (dispatch) begin
      head_due_wide[TIME_BITS-1:0]  = due_w[1];
      head_task_wide[TASK_BITS-1:0] = task_w[1];
    end
    cnt_wide[CNT_W-1:0] = count_nxt;
  end

  logic [dtq_pkg::OUT_TDATA_W-1:0] res_tdata;
  logic [dtq_pkg::OUT_TUSER_W-1:0] res_tuser;

  assign res_tdata = {2'b00,
                      (count_nxt == '0),
                      cnt_wide[dtq_pkg::OCC_W-1:0],
                      head_due_wide[dtq_pkg::TIME_W-1:0],
                      head_task_wide[dtq_pkg::TASK_W-1:0]};
  assign res_tuser = {reject, dispatch};

  // output register
  logic                            out_valid_r;
  logic [dtq_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [dtq_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      out_tdata_r <= res_tdata;
      out_tuser_r <= res_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### hdl/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks for the deadline task queue, bound to the top level.
// ----------------------------------------------------------------------------
module dtq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dtq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [dtq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a transaction is never both a dispatch and a rejection
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("dispatched and rejected together");

  // no dispatch means empty task and due fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[39:0] == '0))
    else $error("payload set without dispatch");

  // empty flag agrees with occupancy
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[45] |-> (out_tdata[44:40] == '0))
    else $error("is_empty with nonzero occupancy");

  // each accepted input gives a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted input");

endmodule

bind deadline_task_queue_top dtq_checker u_dtq_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadline task queue stream block.
// ----------------------------------------------------------------------------
// A shadow copy of the sorted queue predicts the reply to every accepted
// input transaction. A monitor compares each output transaction, field by
// field, with the oldest predicted reply. The named tests cover the corner
// cases, equal due times, a full queue, a long output stall, a quiet pause
// and a long random run. Both sides idle in short random bursts, except in
// the final part of the run.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DEPTH = dtq_pkg::DEPTH_DEF;

  // One predicted reply, one member per result field
  typedef struct {
    bit        dispatched;
    bit [7:0]  task_no;
    bit [31:0] due;
    bit        rejected;
    bit [4:0]  occ;
    bit        empty;
  } reply_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tuser   = 1'b0;
  logic [dtq_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tready = 1'b0;
  // in_tdata:  [7:0] task_number, [39:8] due_time, [71:40] current_time
  // in_tuser:  [0] opcode
  wire                             in_tready;
  wire                             out_tvalid;
  // out_tdata: [7:0] out_task_number, [39:8] out_due_time, [44:40] occupancy,
  //            [45] is_empty, [47:46] zero
  wire [dtq_pkg::OUT_TDATA_W-1:0]  out_tdata;
  // out_tuser: [0] dispatched, [1] rejected
  wire [dtq_pkg::OUT_TUSER_W-1:0]  out_tuser;

  // Shadow of the sorted row, slot 0 is the earliest due time
  bit [31:0] shadow_due  [DEPTH];
  bit [7:0]  shadow_task [DEPTH];
  int        shadow_count = 0;

  reply_t    awaited_replies[$];
  int        mismatches   = 0;
  bit        allow_idle   = 1'b1;  // random bursts of idling on both sides
  int        hold_cycles  = 0;     // long receiver hold-off, counted down
  bit [31:0] sim_now      = 32'd0; // running clock for well-formed polls
  int        enq_percent  = 50;

  deadline_task_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predict the reply to one transaction and advance the shadow queue.
  function automatic reply_t schedule_reply(dtq_pkg::dtq_op_t op, bit [7:0] tn,
                                            bit [31:0] due, bit [31:0] now);
    reply_t r;
    int     pos;
    r = '{default: '0};
    if (op == dtq_pkg::OP_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        // behind every entry with due <= new due: ties stay FIFO
        pos = 0;
        while (pos < shadow_count && shadow_due[pos] <= due) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_due[k]  = shadow_due[k-1];
          shadow_task[k] = shadow_task[k-1];
        end
        shadow_due[pos]  = due;
        shadow_task[pos] = tn;
        shadow_count++;
      end
    end else if (shadow_count != 0 && shadow_due[0] <= now) begin
      r.dispatched = 1'b1;
      r.task_no    = shadow_task[0];
      r.due        = shadow_due[0];
      for (int k = 0; k + 1 < shadow_count; k++) begin
        shadow_due[k]  = shadow_due[k+1];
        shadow_task[k] = shadow_task[k+1];
      end
      shadow_count--;
    end
    r.occ   = shadow_count[4:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // Offer one transaction; returns once an edge has accepted it. Readiness is
  // sampled at the falling edge, where every handshake signal is settled.
  task automatic send_item(dtq_pkg::dtq_op_t op, bit [7:0] tn, bit [31:0] due,
                           bit [31:0] now);
    reply_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {now, due, tn};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predicted = schedule_reply(op, tn, due, now);
    awaited_replies.insert(awaited_replies.size(), predicted);
    // occasional sender gap
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Sender stops until the block has delivered every predicted reply.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    wait (awaited_replies.size() == 0);
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: due times near a running clock, polls at that
  // clock. Fields a transaction ignores still carry random bits.
  task automatic random_item();
    dtq_pkg::dtq_op_t op;
    bit [7:0]         tn;
    bit [31:0]        due;
    bit [31:0]        now;
    op  = ($urandom_range(0, 99) < enq_percent) ? dtq_pkg::OP_ENQ : dtq_pkg::OP_POLL;
    tn  = 8'($urandom);
    due = $urandom;
    now = $urandom;
    if (op == dtq_pkg::OP_ENQ) begin
      if ($urandom_range(0, 9) != 0) due = sim_now + $urandom_range(0, 200);
    end else begin
      sim_now = sim_now + $urandom_range(0, 60);
      if ($urandom_range(0, 9) != 0) now = sim_now;
    end
    send_item(op, tn, due, now);
  endtask

  // Receiver: long hold-off when asked, else random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (allow_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Reply checker: a transaction completes at the next rising edge
  always @(negedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[31:0], 32'd0);
      end else begin
        want = awaited_replies[0];
        awaited_replies.delete(0);
        if (out_tuser[0] !== want.dispatched)
          report_mismatch("dispatched", 32'(out_tuser[0]), 32'(want.dispatched));
        if (out_tdata[7:0] !== want.task_no)
          report_mismatch("out_task_number", 32'(out_tdata[7:0]), 32'(want.task_no));
        if (out_tdata[39:8] !== want.due)
          report_mismatch("out_due_time", out_tdata[39:8], want.due);
        if (out_tuser[1] !== want.rejected)
          report_mismatch("rejected", 32'(out_tuser[1]), 32'(want.rejected));
        if (out_tdata[44:40] !== want.occ)
          report_mismatch("occupancy", 32'(out_tdata[44:40]), 32'(want.occ));
        if (out_tdata[45] !== want.empty)
          report_mismatch("is_empty", 32'(out_tdata[45]), 32'(want.empty));
        if (out_tdata[47:46] !== 2'b00)
          report_mismatch("reserved bits", 32'(out_tdata[47:46]), 32'd0);
      end
    end
  end

  // Extremes of every field, poll on empty, head not yet due
  task automatic test_corner_values();
    send_item(dtq_pkg::OP_POLL, 8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(dtq_pkg::OP_POLL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(dtq_pkg::OP_ENQ,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(dtq_pkg::OP_ENQ,  8'h00, 32'h0000_0000, 32'h0000_0000);
    send_item(dtq_pkg::OP_POLL, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(dtq_pkg::OP_POLL, 8'h00, 32'h0000_0000, 32'hFFFF_FFFE);
    send_item(dtq_pkg::OP_POLL, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // Fill with interleaved equal due times, overflow once, then drain some
  task automatic test_full_and_ties();
    for (int i = 0; i < DEPTH; i++)
      send_item(dtq_pkg::OP_ENQ, 8'(8'h10 + i), (i % 2) ? 32'd3 : 32'd7, 32'd0);
    send_item(dtq_pkg::OP_ENQ, 8'hA5, 32'd1, 32'd0);
    send_item(dtq_pkg::OP_POLL, 8'h00, 32'd0, 32'd2);
    for (int i = 0; i < 5; i++)
      send_item(dtq_pkg::OP_POLL, 8'h00, 32'd0, 32'hFFFF_FFFF);
  endtask

  // Receiver holds off while items keep coming: the input must stall
  task automatic test_output_hold();
    hold_cycles = 80;
    for (int i = 0; i < 30; i++) random_item();
  endtask

  // Sender waits for every reply between two bursts
  task automatic test_quiet_pause();
    for (int i = 0; i < 12; i++) random_item();
    drain_replies();
    for (int i = 0; i < 12; i++) random_item();
  endtask

  // Long random run; the enqueue share changes per segment so the queue
  // swings between empty and full
  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_percent = 30;
          1: enq_percent = 50;
          default: enq_percent = 80;
        endcase
      end
      random_item();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_values();
    test_full_and_ties();
    test_output_hold();
    test_quiet_pause();
    test_random_traffic(1250);

    // closing stretch runs back to back on both sides
    allow_idle = 1'b0;
    test_random_traffic(200);

    drain_replies();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("deadline_task_queue_top regression: pass");
    end else begin
      $display("deadline_task_queue_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("deadline_task_queue_top regression: fail");
    $finish;
  end

endmodule

### filelist.f
hdl/dtq_pkg.sv
hdl/dtq_cell.sv
hdl/deadline_task_queue_top.sv
hdl/dtq_checker.sv
bench/tb.sv
